### hw/rtl/fpd_pkg.sv
package fpd_pkg;

    // Store geometry
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int RAD_W      = 20;
    localparam int SQ_W       = 2 * RAD_W;
    localparam int OUT_IDX_W  = 6;

    localparam logic [RAD_W-1:0] RADIUS_RESET    = RAD_W'(5000);
    localparam logic [SQ_W-1:0]  RADIUS_SQ_RESET = SQ_W'(25000000);

    // Tag that follows one stored point through the distance pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] index;
    } scan_tag_t;

    // Arrival index as reported: low bits of the store index
    function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [IDX_W-1:0] v);
        logic [IDX_W+OUT_IDX_W-1:0] t;
        t = (IDX_W + OUT_IDX_W)'(v);
        return t[OUT_IDX_W-1:0];
    endfunction

endpackage

### hw/rtl/fpd_point_mem.sv
module fpd_point_mem
    import fpd_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [COORD_W-1:0] wr_x,
    input  logic [COORD_W-1:0] wr_y,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [COORD_W-1:0] rd_x,
    output logic [COORD_W-1:0] rd_y
);

    logic [2*COORD_W-1:0] mem [MAX_POINTS];
    logic [2*COORD_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_x = rd_data_reg[2*COORD_W-1:COORD_W];
    assign rd_y = rd_data_reg[COORD_W-1:0];

endmodule

### hw/rtl/fpd_dist_pipe.sv
module fpd_dist_pipe
    import fpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COORD_W-1:0] pt_x,
    input  logic [COORD_W-1:0] pt_y,
    input  logic [COORD_W-1:0] new_x,
    input  logic [COORD_W-1:0] new_y,
    input  logic [RAD_W-1:0]   radius,
    input  logic [SQ_W-1:0]    radius_sq,
    input  scan_tag_t          tag_in,
    output logic               hit,
    output scan_tag_t          tag_out
);

    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [DIFF_W-1:0]        abs_x, abs_y;
    logic [RAD_W-1:0]         ax_reg, ay_reg;
    logic                     near_reg, near3_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [SQ_W:0]            sq_sum;
    logic                     hit_reg;
    scan_tag_t                tag1_reg, tag2_reg, tag3_reg, tag4_reg;

    // Stage 1: signed differences
    always_ff @(posedge clk)
    begin
        dx_reg <= $signed({new_x[COORD_W-1], new_x}) - $signed({pt_x[COORD_W-1], pt_x});
        dy_reg <= $signed({new_y[COORD_W-1], new_y}) - $signed({pt_y[COORD_W-1], pt_y});
    end

    // Stage 2: magnitudes, early reject at the radius
    assign abs_x = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
    assign abs_y = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);

    always_ff @(posedge clk)
    begin
        ax_reg   <= abs_x[RAD_W-1:0];
        ay_reg   <= abs_y[RAD_W-1:0];
        near_reg <= (abs_x < DIFF_W'(radius)) && (abs_y < DIFF_W'(radius));
    end

    // Stage 3: squares, both below 2^40
    always_ff @(posedge clk)
    begin
        sqx_reg   <= ax_reg * ax_reg;
        sqy_reg   <= ay_reg * ay_reg;
        near3_reg <= near_reg;
    end

    // Stage 4: sum against radius squared
    assign sq_sum = (SQ_W + 1)'(sqx_reg) + (SQ_W + 1)'(sqy_reg);

    always_ff @(posedge clk)
    begin
        hit_reg <= near3_reg && (sq_sum < (SQ_W + 1)'(radius_sq));
    end

    // Tags travel alongside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    assign hit     = hit_reg;
    assign tag_out = tag4_reg;

    // Assertions
    a_hit_needs_valid_history: assert property (@(posedge clk) disable iff (!rst_n)
        tag_out.valid |-> $past(tag_in.valid, 4))
        else $error("pipeline tag appeared without an issued read");

endmodule

### hw/rtl/fixed_radius_pair_detector_top.sv
// Busy stays high while an item is processed and drops in the same cycle as the
// last result of that item leaves. A new item is taken only while idle; a scan is
// bounded by the single read port of the point memory (one stored point a cycle)
// plus the four-stage distance pipeline. An empty or full store gives its single
// result without a scan. Results cannot be stalled by the receiver.
// Reset (rst_n low, asynchronous) empties the store and sets radius to 5000.
module fixed_radius_pair_detector_top
    import fpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 restart,
    input  logic [COORD_W-1:0]   pos_x,
    input  logic [COORD_W-1:0]   pos_y,
    input  logic                 cfg_we,
    input  logic [RAD_W-1:0]     cfg_wdata,
    output logic                 result_valid,
    output logic                 pair_valid,
    output logic [OUT_IDX_W-1:0] earlier_index,
    output logic [OUT_IDX_W-1:0] later_index,
    output logic                 last,
    output logic                 overflow
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_OVF   = 3'd4;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_POINTS);

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, cnt_eff;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [COORD_W-1:0] nx_reg, ny_reg;
    logic [RAD_W-1:0]   radius_reg;
    logic [SQ_W-1:0]    radius_sq_reg;
    scan_tag_t          tag0_reg, tag0_next;
    logic               flush_reg;
    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               accept;
    logic               scan_last;

    logic [COORD_W-1:0] mem_x, mem_y;
    logic               pipe_hit;
    scan_tag_t          pipe_tag;

    logic                 res_valid_reg, res_valid_next;
    logic                 res_pair_reg, res_pair_next;
    logic [OUT_IDX_W-1:0] res_early_reg, res_early_next;
    logic [OUT_IDX_W-1:0] res_later_reg, res_later_next;
    logic                 res_last_reg, res_last_next;
    logic                 res_ovf_reg, res_ovf_next;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cnt_eff   = restart ? '0 : cnt_reg;
    assign scan_last = (rd_cnt_reg == IDX_W'(idx_reg - 1'b1));

    // Point store
    fpd_point_mem u_mem (
        .clk     (clk),
        .wr_en   (accept && (cnt_eff < FULL_CNT)),
        .wr_addr (cnt_eff[IDX_W-1:0]),
        .wr_x    (pos_x),
        .wr_y    (pos_y),
        .rd_addr (rd_cnt_reg),
        .rd_x    (mem_x),
        .rd_y    (mem_y)
    );

    // Distance test
    fpd_dist_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_x      (mem_x),
        .pt_y      (mem_y),
        .new_x     (nx_reg),
        .new_y     (ny_reg),
        .radius    (radius_reg),
        .radius_sq (radius_sq_reg),
        .tag_in    (tag0_reg),
        .hit       (pipe_hit),
        .tag_out   (pipe_tag)
    );

    // Sequencer and result selection
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        rd_cnt_next     = rd_cnt_reg;
        tag0_next       = '0;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        res_valid_next  = 1'b0;
        res_pair_next   = 1'b0;
        res_early_next  = '0;
        res_later_next  = '0;
        res_last_next   = 1'b0;
        res_ovf_next    = 1'b0;

        // A new pair pushes out the one held back, which is then not the last
        if (pipe_tag.valid && pipe_hit)
        begin
            if (pend_valid_reg)
            begin
                res_valid_next = 1'b1;
                res_pair_next  = 1'b1;
                res_early_next = out_idx(pend_idx_reg);
                res_later_next = out_idx(idx_reg);
            end
            pend_valid_next = 1'b1;
            pend_idx_next   = pipe_tag.index;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_valid_next = 1'b0;
                    rd_cnt_next     = '0;
                    if (cnt_eff >= FULL_CNT)
                    begin
                        cnt_next   = cnt_eff;
                        state_next = ST_OVF;
                    end
                    else
                    begin
                        idx_next   = cnt_eff[IDX_W-1:0];
                        cnt_next   = CNT_W'(cnt_eff + 1'b1);
                        state_next = (cnt_eff == '0) ? ST_EMPTY : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                tag0_next.valid = 1'b1;
                tag0_next.last  = scan_last;
                tag0_next.index = rd_cnt_reg;
                rd_cnt_next     = IDX_W'(rd_cnt_reg + 1'b1);
                if (scan_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (flush_reg)
                begin
                    res_valid_next = 1'b1;
                    res_pair_next  = pend_valid_reg;
                    res_early_next = pend_valid_reg ? out_idx(pend_idx_reg) : '0;
                    res_later_next = out_idx(idx_reg);
                    res_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                res_valid_next = 1'b1;
                res_later_next = out_idx(idx_reg);
                res_last_next  = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_OVF:
            begin
                res_valid_next = 1'b1;
                res_last_next  = 1'b1;
                res_ovf_next   = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rd_cnt_reg     <= '0;
            tag0_reg       <= '0;
            flush_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            radius_reg     <= RADIUS_RESET;
            radius_sq_reg  <= RADIUS_SQ_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_cnt_reg     <= rd_cnt_next;
            tag0_reg       <= tag0_next;
            flush_reg      <= pipe_tag.valid && pipe_tag.last;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            radius_sq_reg  <= radius_reg * radius_reg;
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pend_idx_reg  <= pend_idx_next;
        res_pair_reg  <= res_pair_next;
        res_early_reg <= res_early_next;
        res_later_reg <= res_later_next;
        res_last_reg  <= res_last_next;
        res_ovf_reg   <= res_ovf_next;
        if (accept)
        begin
            nx_reg <= pos_x;
            ny_reg <= pos_y;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_valid  = res_valid_reg;
    assign pair_valid    = res_pair_reg;
    assign earlier_index = res_early_reg;
    assign later_index   = res_later_reg;
    assign last          = res_last_reg;
    assign overflow      = res_ovf_reg;

    // Assertions
    a_idle_pipe_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!tag0_reg.valid && !flush_reg))
        else $error("distance pipeline active while idle");

    a_accept_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !result_valid)
        else $error("result in the cycle after an item was accepted");

    a_nonlast_is_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> pair_valid)
        else $error("non-final result carries no pair");

    a_overflow_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overflow) |-> (!pair_valid && last))
        else $error("overflow result malformed");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import fpd_pkg::*;

    // Run length and pacing
    localparam int RAND_ITEMS   = 310;
    localparam int QUIET_ITEMS  = 50;      // last stretch runs without gaps
    localparam int DRAIN_CYCLES = 8;       // busy drops with the last result
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 20;

    // One result of the block
    typedef struct packed {
        logic                 pair_valid;
        logic [OUT_IDX_W-1:0] earlier;
        logic [OUT_IDX_W-1:0] later;
        logic                 last_flag;
        logic                 ovf;
    } pair_result_t;

    typedef enum logic {ROW_POINT, ROW_RADIUS} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               restart;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RAD_W-1:0]   rad;
        logic               typed;
        pair_result_t       want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 restart = 1'b0;
    logic [COORD_W-1:0]   pos_x = '0;
    logic [COORD_W-1:0]   pos_y = '0;
    logic                 cfg_we = 1'b0;
    logic [RAD_W-1:0]     cfg_wdata = '0;
    logic                 result_valid;
    logic                 pair_valid;
    logic [OUT_IDX_W-1:0] earlier_index;
    logic [OUT_IDX_W-1:0] later_index;
    logic                 last;
    logic                 overflow;

    // Expectation typed into a directed row, held with the item
    logic                 typed_row = 1'b0;
    pair_result_t         typed_want = '0;

    // Predictor state
    logic [RAD_W-1:0]     model_radius = RADIUS_RESET;
    logic [COORD_W-1:0]   store_x [MAX_POINTS];
    logic [COORD_W-1:0]   store_y [MAX_POINTS];
    int unsigned          stored_count = 0;
    pair_result_t         pending_pairs [$];

    // Bookkeeping
    int unsigned points_accepted = 0;
    int unsigned results_seen    = 0;
    int unsigned pairs_seen      = 0;
    int unsigned overflows_seen  = 0;
    int unsigned radius_writes   = 0;
    int unsigned errors          = 0;
    int unsigned cycle_cnt       = 0;

    stim_row_t dir_rows [$];

    fixed_radius_pair_detector_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .restart       (restart),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_valid  (result_valid),
        .pair_valid    (pair_valid),
        .earlier_index (earlier_index),
        .later_index   (later_index),
        .last          (last),
        .overflow      (overflow)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    // Appends one expected result
    function automatic void expect_result(input pair_result_t res);
        pending_pairs = {pending_pairs, res};
    endfunction

    // Works out the results of one point and updates the point store
    function automatic void predict_pairs(input logic rs, input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y);
        longint       nx;
        longint       ny;
        longint       dx;
        longint       dy;
        longint       r;
        int unsigned  idx;
        int           found;
        pair_result_t res;
        nx = longint'($signed(x));
        ny = longint'($signed(y));
        r = longint'(model_radius);
        found = 0;
        if (rs)
            stored_count = 0;
        // full store: point dropped, nothing compared
        if (stored_count >= MAX_POINTS)
        begin
            res = '{1'b0, '0, '0, 1'b1, 1'b1};
            expect_result(res);
            return;
        end
        idx = stored_count;
        for (int i = 0; i < idx; i++)
        begin
            dx = nx - longint'($signed(store_x[i]));
            dy = ny - longint'($signed(store_y[i]));
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            if (dx < r && dy < r && dx * dx + dy * dy < r * r)
            begin
                res = '{1'b1, OUT_IDX_W'(i), OUT_IDX_W'(idx), 1'b0, 1'b0};
                expect_result(res);
                found++;
            end
        end
        store_x[idx] = x;
        store_y[idx] = y;
        stored_count = idx + 1;
        if (found == 0)
        begin
            res = '{1'b0, '0, OUT_IDX_W'(idx), 1'b1, 1'b0};
            expect_result(res);
        end
        else
        begin
            res = pending_pairs.pop_back();
            res.last_flag = 1'b1;
            expect_result(res);
        end
    endfunction

    // Result check, then item acceptance and register writes
    always @(posedge clk)
    begin : monitor
        pair_result_t got;
        pair_result_t want;
        int           n_before;
        if (rst_n)
        begin
            if (result_valid)
            begin
                got = '{pair_valid, earlier_index, later_index, last, overflow};
                results_seen++;
                if (pair_valid)
                    pairs_seen++;
                if (overflow)
                    overflows_seen++;
                if (pending_pairs.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: unexpected result: %s valid=%0b e=%0d l=%0d %s",
                                 $time, "expected none, got", got.pair_valid,
                                 got.earlier, got.later,
                                 $sformatf("last=%0b ovf=%0b", got.last_flag, got.ovf));
                end
                else
                begin
                    want = pending_pairs.pop_front();
                    if (got.pair_valid !== want.pair_valid || got.earlier !== want.earlier ||
                        got.later !== want.later || got.last_flag !== want.last_flag ||
                        got.ovf !== want.ovf)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                        begin
                            $display("%0t: mismatch: expected valid=%0b e=%0d l=%0d %s",
                                     $time, want.pair_valid, want.earlier, want.later,
                                     $sformatf("last=%0b ovf=%0b",
                                               want.last_flag, want.ovf));
                            $display("%0t: mismatch: got valid=%0b e=%0d l=%0d %s",
                                     $time, got.pair_valid, got.earlier, got.later,
                                     $sformatf("last=%0b ovf=%0b",
                                               got.last_flag, got.ovf));
                        end
                    end
                end
            end
            if (cfg_we)
                model_radius = cfg_wdata;
            if (start && !busy)
            begin
                n_before = pending_pairs.size();
                predict_pairs(restart, pos_x, pos_y);
                // directed rows with a typed answer replace the prediction
                if (typed_row)
                begin
                    while (pending_pairs.size() > n_before)
                        void'(pending_pairs.pop_back());
                    expect_result(typed_want);
                end
                points_accepted++;
            end
        end
    end

    // Presents one item and waits until it is taken
    task automatic send_point(input logic rs, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic typed,
                              input pair_result_t want);
        int unsigned seen;
        seen = points_accepted;
        restart = rs;
        pos_x = x;
        pos_y = y;
        typed_row = typed;
        typed_want = want;
        start = 1'b1;
        do
            @(negedge clk);
        while (points_accepted == seen);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_radius(input logic [RAD_W-1:0] v);
        wait_drained();
        cfg_wdata = v;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        radius_writes++;
    endtask

    // Appends one row to the directed table
    function automatic void add_row(input stim_row_t row);
        dir_rows = {dir_rows, row};
    endfunction

    function automatic stim_row_t point_row(input logic rs, input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
        stim_row_t row;
        row = '{ROW_POINT, rs, x, y, '0, 1'b0, '0};
        return row;
    endfunction

    // point that finds no partner: one result with its own index
    function automatic stim_row_t lone_row(input logic rs, input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y,
                                           input logic [OUT_IDX_W-1:0] idx);
        stim_row_t row;
        row = '{ROW_POINT, rs, x, y, '0, 1'b1, '{1'b0, '0, idx, 1'b1, 1'b0}};
        return row;
    endfunction

    function automatic stim_row_t radius_row(input logic [RAD_W-1:0] v);
        stim_row_t row;
        row = '{ROW_RADIUS, 1'b0, '0, '0, v, 1'b0, '0};
        return row;
    endfunction

    // Watchdog
    initial
    begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [RAD_W-1:0]   rad;
        logic [RAD_W-1:0]   first_radii [4];
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               rs;
        int unsigned        spread;
        int unsigned        seq_len;
        int unsigned        rand_sent;
        int unsigned        sel;
        bit                 fill;
        bit                 noisy;
        bit                 idle_on;

        first_radii = '{20'd5000, 20'd0, 20'hFFFFF, 20'd1};

        // Directed table, radius 5000 out of reset
        add_row(lone_row(1'b1, 32'd0, 32'd0, 6'd0));
        add_row(point_row(1'b0, 32'd4999, 32'd0));
        add_row(lone_row(1'b0, 32'd0, 32'd5000, 6'd2));
        add_row(point_row(1'b0, 32'd3000, 32'd4000));
        add_row(lone_row(1'b0, 32'h8000_0000, 32'h8000_0000, 6'd4));
        add_row(lone_row(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd5));
        add_row(lone_row(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 6'd6));
        add_row(point_row(1'b0, 32'h8000_0001, 32'h8000_0000));
        add_row(point_row(1'b0, 32'h7FFF_FFFE, 32'h7FFF_FFFF));
        add_row(point_row(1'b0, 32'h7FFF_FFFF, 32'h8000_0000));
        // tight cluster: several pairs for one point
        add_row(lone_row(1'b1, 32'd100, 32'd100, 6'd0));
        add_row(point_row(1'b0, 32'd101, 32'd100));
        add_row(point_row(1'b0, 32'd100, 32'd101));
        add_row(point_row(1'b0, 32'd99, 32'd99));
        // zero radius never pairs, even for equal points
        add_row(radius_row(20'd0));
        add_row(lone_row(1'b1, 32'd7, 32'd7, 6'd0));
        add_row(lone_row(1'b0, 32'd7, 32'd7, 6'd1));
        // largest radius, pairs near the edge of the circle
        add_row(radius_row(20'hFFFFF));
        add_row(point_row(1'b0, 32'd7, 32'd1048581));
        add_row(point_row(1'b0, 32'd741462, 32'd741462));
        // radius one: only coincident points pair
        add_row(radius_row(20'd1));
        add_row(lone_row(1'b1, -32'sd5, -32'sd5, 6'd0));
        add_row(point_row(1'b0, -32'sd5, -32'sd5));
        add_row(lone_row(1'b0, -32'sd4, -32'sd5, 6'd2));

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_RADIUS)
                write_radius(dir_rows[i].rad);
            else
                send_point(dir_rows[i].restart, dir_rows[i].x, dir_rows[i].y,
                           dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases: a radius setting, then a run of clustered or scattered points
        rand_sent = 0;
        for (int phase = 0; rand_sent < RAND_ITEMS; phase++)
        begin
            if (phase < 4)
                rad = first_radii[phase];
            else
            begin
                sel = $urandom_range(0, 3);
                case (sel)
                    0: rad = RAD_W'($urandom_range(0, 15));
                    1: rad = RAD_W'($urandom_range(16, 20000));
                    2: rad = RAD_W'($urandom_range(20001, 1048575));
                    default: rad = RADIUS_RESET;
                endcase
            end
            write_radius(rad);

            // the first phase, and some later ones, run the store full
            fill = (phase == 0) || ($urandom_range(0, 5) == 0);
            seq_len = fill ? $urandom_range(66, 70) : $urandom_range(3, 20);
            // a phase that reaches the quiet stretch runs on to the end
            if (rand_sent + seq_len + QUIET_ITEMS >= RAND_ITEMS)
                seq_len = RAND_ITEMS - rand_sent;
            noisy = ($urandom_range(0, 3) == 0);
            idle_on = ($urandom_range(0, 2) != 0);
            spread = rad + rad / 2 + 2;
            cx = $urandom;
            cy = $urandom;

            for (int k = 0; k < seq_len; k++)
            begin
                if (k == 0)
                    rs = (phase == 0) || ($urandom_range(0, 3) != 0);
                else
                    rs = !fill && ($urandom_range(0, 31) == 0);
                if (noisy)
                begin
                    x = $urandom;
                    y = $urandom;
                end
                else
                begin
                    x = cx + ($urandom_range(0, 2 * spread) - spread);
                    y = cy + ($urandom_range(0, 2 * spread) - spread);
                end
                if (idle_on && rand_sent < RAND_ITEMS - QUIET_ITEMS &&
                    $urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 8)) @(negedge clk);
                send_point(rs, x, y, 1'b0, '0);
                rand_sent++;
            end
        end

        wait_drained();
        if (pending_pairs.size() != 0)
            errors++;

        $display("Covered %0d points over %0d radius settings:",
                 points_accepted, radius_writes);
        $display("%0d results, %0d pairs, %0d overflows.",
                 results_seen, pairs_seen, overflows_seen);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/fpd_pkg.sv
hw/rtl/fpd_point_mem.sv
hw/rtl/fpd_dist_pipe.sv
hw/rtl/fixed_radius_pair_detector_top.sv
tb/tb.sv
